// ===== rtl/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned ROUNDS      = 64;
  localparam logic [6:0]  LEN_POS     = 7'd56;
  localparam logic [6:0]  FULL_POS    = 7'd64;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [2:0]  WORD_BYTES  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Source of the bytes pushed into the block buffer.
  typedef enum logic [2:0] {
    STG_MSG,
    STG_PAD,
    STG_ZERO,
    STG_LEN_HI,
    STG_LEN_LO,
    STG_FIN
  } stage_t;

  typedef struct packed {
    logic init;  // chain back to initial values
    logic load;  // working vars from chain, schedule from buffer
    logic step;  // one round
    logic fold;  // chain += working vars
  } core_ctrl_t;

  localparam logic [31:0] IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha_in_if.sv =====
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

// ===== rtl/sha_out_if.sv =====
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest;

  modport source (output valid, digest_word, word_index, last_digest, input ready);
  modport sink   (input valid, digest_word, word_index, last_digest, output ready);
endinterface

// ===== rtl/sha_sched.sv =====
module sha_sched (
  input  logic                 clk,
  input  sha_pkg::core_ctrl_t  ctrl,
  input  logic [511:0]         blk,
  output logic [31:0]          w_t
);

  logic [31:0] w_r [0:15];
  logic [31:0] w_new;

  // W[t+16] from the sixteen-word window
  assign w_new = sha_pkg::small_sigma1(w_r[14]) + w_r[9]
               + sha_pkg::small_sigma0(w_r[1]) + w_r[0];
  assign w_t   = w_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= blk[511 - 32*i -: 32];
      end
    end else if (ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule

// ===== rtl/sha_core.sv =====
module sha_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::core_ctrl_t  ctrl,
  input  logic [5:0]           round_idx,
  input  logic [31:0]          w_t,
  output logic [31:0]          chain [0:7]
);

  logic [31:0] chain_r [0:7];
  logic [31:0] wv_r    [0:7];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_f;
  logic [31:0] maj_f;

  assign ch_f  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign maj_f = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t1    = wv_r[7] + sha_pkg::big_sigma1(wv_r[4]) + ch_f
               + sha_pkg::K[round_idx] + w_t;
  assign t2    = sha_pkg::big_sigma0(wv_r[0]) + maj_f;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain[i] = chain_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha_pkg::IV[i];
      end
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + wv_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 8; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (ctrl.step) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/sha256_hash_engine.sv =====
// SHA-256 engine. Message words arrive on in_chan (valid/ready), big-endian,
// with a count of valid leading bytes; only the word flagged last_word may be
// short, and it may be empty. After the last word the engine pads the message
// (0x80, zeros, 64-bit bit length) and returns the eight digest words on
// out_chan, word_index 0 first, last_digest set on word 7.
// Flow: a word is taken in the idle cycle and shifted into the 64-byte
// block buffer in the next; no further word is taken until it is in. Each
// full block runs the 64 rounds of the single round unit, then the chain
// fold, then resumes feeding, with in_chan.ready low throughout. After the
// last word come the pad byte, the zero fill, the two length words, a
// closing step, one or two block compressions, then the 8 digest words.
// Reset (rst_n low, synchronous) restores the initial hash values and clears
// the bit count and fill position; the engine comes up idle and ready.
// A stalled out_chan holds the current digest word; no new message word is
// taken until all eight digest words have been delivered, after which the
// hash state is back at its initial values for the next message.
module sha256_hash_engine (
  input  logic          clk,
  input  logic          rst_n,
  sha_in_if.sink        in_chan,
  sha_out_if.source     out_chan
);

  sha_pkg::state_t     state_r, state_nxt;
  sha_pkg::stage_t     stage_r, stage_nxt;
  sha_pkg::core_ctrl_t ctrl;

  logic [5:0]   fill_r, fill_nxt;
  logic [31:0]  pend_data_r, pend_data_nxt;
  logic [2:0]   pend_n_r, pend_n_nxt;
  logic         pend_last_r, pend_last_nxt;
  logic [63:0]  bit_cnt_r, bit_cnt_nxt;
  logic [6:0]   round_r, round_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [511:0] blk_r, blk_nxt;

  logic [6:0]   need;
  logic [6:0]   room;
  logic [6:0]   new_fill;
  logic [2:0]   avail;
  logic [2:0]   take;
  logic [2:0]   left;
  logic [2:0]   in_bytes;
  logic [31:0]  chunk;
  logic [31:0]  chunk_rest;
  logic         full;
  logic [31:0]  w_t;
  logic [31:0]  chain [0:7];

  // Zero bytes still owed before the length field (wrap to next block past 56)
  assign need = ({1'b0, fill_r} <= sha_pkg::LEN_POS) ? (sha_pkg::LEN_POS - {1'b0, fill_r})
                                                     : (sha_pkg::FULL_POS - {1'b0, fill_r});
  assign room = sha_pkg::FULL_POS - {1'b0, fill_r};

  always_comb begin
    unique case (stage_r)
      sha_pkg::STG_ZERO: begin
        avail = (need >= {4'd0, sha_pkg::WORD_BYTES}) ? sha_pkg::WORD_BYTES : need[2:0];
        chunk = '0;
      end
      sha_pkg::STG_FIN: begin
        avail = '0;
        chunk = pend_data_r;
      end
      default: begin
        avail = pend_n_r;
        chunk = pend_data_r;
      end
    endcase
  end

  assign take     = (room < {4'd0, avail}) ? room[2:0] : avail;
  assign left     = avail - take;
  assign new_fill = {1'b0, fill_r} + {4'd0, take};
  assign full     = (new_fill == sha_pkg::FULL_POS);
  assign in_bytes = (in_chan.valid_bytes > sha_pkg::WORD_BYTES) ? sha_pkg::WORD_BYTES
                                                                 : in_chan.valid_bytes;

  // Shift the leading bytes of the chunk into the bottom of the buffer
  always_comb begin
    unique case (take)
      3'd1: begin
        blk_nxt    = {blk_r[503:0], chunk[31:24]};
        chunk_rest = {chunk[23:0], 8'h00};
      end
      3'd2: begin
        blk_nxt    = {blk_r[495:0], chunk[31:16]};
        chunk_rest = {chunk[15:0], 16'h0000};
      end
      3'd3: begin
        blk_nxt    = {blk_r[487:0], chunk[31:8]};
        chunk_rest = {chunk[7:0], 24'h000000};
      end
      3'd4: begin
        blk_nxt    = {blk_r[479:0], chunk};
        chunk_rest = '0;
      end
      default: begin
        blk_nxt    = blk_r;
        chunk_rest = chunk;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    fill_nxt      = fill_r;
    pend_data_nxt = pend_data_r;
    pend_n_nxt    = pend_n_r;
    pend_last_nxt = pend_last_r;
    bit_cnt_nxt   = bit_cnt_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    ctrl          = '0;
    in_chan.ready = 1'b0;
    out_chan.valid = 1'b0;

    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          pend_data_nxt = in_chan.message_word;
          pend_n_nxt    = in_bytes;
          pend_last_nxt = in_chan.last_word;
          stage_nxt     = sha_pkg::STG_MSG;
          bit_cnt_nxt   = bit_cnt_r + {58'd0, in_bytes, 3'b000};
          state_nxt     = sha_pkg::ST_FEED;
        end
      end

      sha_pkg::ST_FEED: begin
        pend_data_nxt = chunk_rest;
        pend_n_nxt    = (stage_r == sha_pkg::STG_ZERO) ? '0 : left;
        if (full) begin
          // Block complete: hand it to the round unit
          fill_nxt  = '0;
          ctrl.load = 1'b1;
          round_nxt = '0;
          state_nxt = sha_pkg::ST_COMP;
        end else begin
          fill_nxt = new_fill[5:0];
          if (left == '0) begin
            unique case (stage_r)
              sha_pkg::STG_MSG: begin
                if (pend_last_r) begin
                  stage_nxt     = sha_pkg::STG_PAD;
                  pend_data_nxt = {sha_pkg::PAD_BYTE, 24'h000000};
                  pend_n_nxt    = 3'd1;
                end else begin
                  state_nxt = sha_pkg::ST_IDLE;
                end
              end
              sha_pkg::STG_PAD: begin
                stage_nxt = sha_pkg::STG_ZERO;
              end
              sha_pkg::STG_ZERO: begin
                if (need == '0) begin
                  stage_nxt     = sha_pkg::STG_LEN_HI;
                  pend_data_nxt = bit_cnt_r[63:32];
                  pend_n_nxt    = sha_pkg::WORD_BYTES;
                end
              end
              sha_pkg::STG_LEN_HI: begin
                stage_nxt     = sha_pkg::STG_LEN_LO;
                pend_data_nxt = bit_cnt_r[31:0];
                pend_n_nxt    = sha_pkg::WORD_BYTES;
              end
              sha_pkg::STG_LEN_LO: begin
                stage_nxt = sha_pkg::STG_FIN;
              end
              sha_pkg::STG_FIN: begin
                bit_cnt_nxt = '0;
                idx_nxt     = '0;
                state_nxt   = sha_pkg::ST_EMIT;
              end
              default: begin
                stage_nxt = sha_pkg::STG_MSG;
              end
            endcase
          end
        end
      end

      sha_pkg::ST_COMP: begin
        ctrl.step = 1'b1;
        round_nxt = round_r + 7'd1;
        if (round_r == 7'(sha_pkg::ROUNDS - 1)) begin
          state_nxt = sha_pkg::ST_FOLD;
        end
      end

      sha_pkg::ST_FOLD: begin
        // Fold the block into the chain, then resume feeding bytes
        ctrl.fold = 1'b1;
        round_nxt = '0;
        state_nxt = sha_pkg::ST_FEED;
      end

      sha_pkg::ST_EMIT: begin
        out_chan.valid = 1'b1;
        if (out_chan.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(sha_pkg::HASH_WORDS - 1)) begin
            ctrl.init = 1'b1;
            stage_nxt = sha_pkg::STG_MSG;
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_chan.digest_word = chain[idx_r];
  assign out_chan.word_index  = idx_r;
  assign out_chan.last_digest = (idx_r == 3'(sha_pkg::HASH_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha_pkg::ST_IDLE;
      stage_r   <= sha_pkg::STG_MSG;
      fill_r    <= '0;
      bit_cnt_r <= '0;
      round_r   <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      stage_r   <= stage_nxt;
      fill_r    <= fill_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      round_r   <= round_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_data_r <= pend_data_nxt;
    pend_n_r    <= pend_n_nxt;
    pend_last_r <= pend_last_nxt;
    blk_r       <= blk_nxt;
  end

  sha_sched u_sched (
    .clk  (clk),
    .ctrl (ctrl),
    .blk  (blk_nxt),
    .w_t  (w_t)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .round_idx (round_r[5:0]),
    .w_t       (w_t),
    .chain     (chain)
  );

  // A block hand-off always restarts the fill position
  a_full_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_FEED && state_nxt == sha_pkg::ST_COMP) |=> (fill_r == '0))
    else $error("fill position not cleared at block hand-off");

  // Round counter never runs past the fold point
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (round_r <= 7'(sha_pkg::ROUNDS)))
    else $error("round counter out of range");

  // Length field always starts word aligned at byte 56
  a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_FEED && stage_r == sha_pkg::STG_LEN_HI) |->
      ({1'b0, fill_r} == sha_pkg::LEN_POS))
    else $error("length field misaligned");

  // Final digest word returns the engine to idle with a cleared count
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last_digest) |=>
      (state_r == sha_pkg::ST_IDLE && bit_cnt_r == '0))
    else $error("engine not idle after final digest word");

  // An accepted word is always worked on next cycle
  a_accept_feed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == sha_pkg::ST_FEED))
    else $error("accepted word not fed");

endmodule
